/* hdl/crc32msb_pkg.sv */
package crc32msb_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned NCOLS  = 8;

    localparam logic [DATA_W-1:0] POLY_RST  = 32'h04C1_1DB7;
    localparam logic [DATA_W-1:0] START_RST = 32'hFFFF_FFFF;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_POLY     = 2'd0,
        REG_REFL_IDX = 2'd1,
        REG_REFL_ENT = 2'd2,
        REG_START    = 2'd3
    } reg_idx_t;

    // Byte-fold entry is linear in the 8-bit index: one column per index bit
    typedef logic [NCOLS-1:0][DATA_W-1:0] col_arr_t;

    typedef struct packed {
        logic [DATA_W-1:0] start_value;
        col_arr_t          cols;
    } cfg_t;

endpackage

/* hdl/crc32msb_regs.sv */
module crc32msb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crc32msb_pkg::ADDR_W-1:0]     paddr,
    input  logic [crc32msb_pkg::DATA_W-1:0]     pwdata,
    output logic [crc32msb_pkg::DATA_W-1:0]     prdata,
    output logic                                pready,
    output crc32msb_pkg::cfg_t                  cfg
);

    function automatic logic [31:0] rev32(input logic [31:0] v);
        logic [31:0] t;
        t = ((v & 32'hAAAA_AAAA) >> 1) | ((v & 32'h5555_5555) << 1);
        t = ((t & 32'hCCCC_CCCC) >> 2) | ((t & 32'h3333_3333) << 2);
        t = ((t & 32'hF0F0_F0F0) >> 4) | ((t & 32'h0F0F_0F0F) << 4);
        t = ((t & 32'hFF00_FF00) >> 8) | ((t & 32'h00FF_00FF) << 8);
        t = {t[15:0], t[31:16]};
        return t;
    endfunction

    // Entry per index bit: 8 LFSR steps on (bit << 24), or bit 31-j if refl_idx
    function automatic crc32msb_pkg::col_arr_t build_cols(
        input logic [31:0] poly,
        input logic        refl_idx,
        input logic        refl_ent
    );
        crc32msb_pkg::col_arr_t c;
        logic [31:0]            r;
        for (int j = 0; j < crc32msb_pkg::NCOLS; j++)
        begin
            r = '0;
            if (refl_idx)
            begin
                r[31-j] = 1'b1;
            end
            else
            begin
                r[24+j] = 1'b1;
            end
            for (int k = 0; k < 8; k++)
            begin
                r = r[31] ? ({r[30:0], 1'b0} ^ poly) : {r[30:0], 1'b0};
            end
            c[j] = refl_ent ? rev32(r) : r;
        end
        return c;
    endfunction

    logic [31:0]            poly_reg, poly_next;
    logic                   refl_idx_reg, refl_idx_next;
    logic                   refl_ent_reg, refl_ent_next;
    logic [31:0]            start_reg, start_next;
    crc32msb_pkg::col_arr_t cols_reg, cols_next;
    logic                   wr_en;
    crc32msb_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = crc32msb_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        poly_next     = poly_reg;
        refl_idx_next = refl_idx_reg;
        refl_ent_next = refl_ent_reg;
        start_next    = start_reg;
        if (wr_en)
        begin
            case (idx)
                crc32msb_pkg::REG_POLY:     poly_next     = pwdata;
                crc32msb_pkg::REG_REFL_IDX: refl_idx_next = pwdata[0];
                crc32msb_pkg::REG_REFL_ENT: refl_ent_next = pwdata[0];
                crc32msb_pkg::REG_START:    start_next    = pwdata;
                default:                    poly_next     = poly_reg;
            endcase
        end
        // columns follow the written values at the same edge
        cols_next = build_cols(poly_next, refl_idx_next, refl_ent_next);
    end

    always_comb
    begin
        case (idx)
            crc32msb_pkg::REG_POLY:     prdata = poly_reg;
            crc32msb_pkg::REG_REFL_IDX: prdata = {31'd0, refl_idx_reg};
            crc32msb_pkg::REG_REFL_ENT: prdata = {31'd0, refl_ent_reg};
            crc32msb_pkg::REG_START:    prdata = start_reg;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg     <= crc32msb_pkg::POLY_RST;
            refl_idx_reg <= 1'b0;
            refl_ent_reg <= 1'b0;
            start_reg    <= crc32msb_pkg::START_RST;
            cols_reg     <= build_cols(crc32msb_pkg::POLY_RST, 1'b0, 1'b0);
        end
        else
        begin
            poly_reg     <= poly_next;
            refl_idx_reg <= refl_idx_next;
            refl_ent_reg <= refl_ent_next;
            start_reg    <= start_next;
            cols_reg     <= cols_next;
        end
    end

    assign cfg.start_value = start_reg;
    assign cfg.cols        = cols_reg;

endmodule

/* hdl/crc32msb_core.sv */
module crc32msb_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  crc32msb_pkg::cfg_t                cfg,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [crc32msb_pkg::DATA_W-1:0]   payload,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [crc32msb_pkg::DATA_W-1:0]   crc_out
);

    // One byte: entry(crc[31:24] ^ b) ^ (crc << 8), entry as XOR of columns
    function automatic logic [31:0] fold(
        input logic [31:0]            crc,
        input logic [7:0]             b,
        input crc32msb_pkg::col_arr_t cols
    );
        logic [7:0]  ix;
        logic [31:0] e;
        ix = crc[31:24] ^ b;
        e  = {crc[23:0], 8'h00};
        for (int j = 0; j < crc32msb_pkg::NCOLS; j++)
        begin
            if (ix[j])
            begin
                e = e ^ cols[j];
            end
        end
        return e;
    endfunction

    logic        s1_valid_reg, s1_valid_next;
    logic        mode_reg;
    logic [31:0] payload_reg;
    logic        restart_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] crc_reg, crc_next;
    logic        out_free, advance, accept;
    logic [31:0] base, f0, f1, f2, f3;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        base = restart_reg ? cfg.start_value : crc_reg;
        f0   = fold(base, mode_reg ? payload_reg[31:24] : payload_reg[7:0], cfg.cols);
        f1   = fold(f0, payload_reg[23:16], cfg.cols);
        f2   = fold(f1, payload_reg[15:8], cfg.cols);
        f3   = fold(f2, payload_reg[7:0], cfg.cols);

        s1_valid_next  = accept || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
        crc_next       = crc_reg;
        if (advance)
        begin
            crc_next = mode_reg ? f3 : f0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= crc32msb_pkg::START_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            payload_reg <= payload;
            restart_reg <= restart;
        end
    end

    // running CRC doubles as the result register
    assign out_valid = out_valid_reg;
    assign crc_out   = crc_reg;

endmodule

/* hdl/crc32_msb_first_configurable_top.sv */
// channel | handshake                   | payload
// --------+-----------------------------+------------------------------
// in      | in_valid / in_stall         | mode, payload[31:0], restart
// out     | out_valid / out_stall       | crc_out[31:0]
// cfg     | psel/penable/pwrite, pready | paddr[3:0], pwdata, prdata
//
// One item per cycle sustained while in_stall stays low; an accepted item
// passes the input register, then the running-CRC/result register, to out_valid.
// Word mode folds all four bytes together through the precomputed entry columns.
// Reset: poly 0x04C11DB7, no reflection, start value and running CRC 0xFFFFFFFF.
// out_stall holding a result raises in_stall in the same cycle only when the
// input register is also full; otherwise a new item is still taken.
// Config writes update the entry columns at the write edge itself.
module crc32_msb_first_configurable_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // item input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [crc32msb_pkg::DATA_W-1:0]   payload,
    input  logic                              restart,
    // result output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [crc32msb_pkg::DATA_W-1:0]   crc_out,
    // APB config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crc32msb_pkg::ADDR_W-1:0]   paddr,
    input  logic [crc32msb_pkg::DATA_W-1:0]   pwdata,
    output logic [crc32msb_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    // start value plus one entry column per index bit
    crc32msb_pkg::cfg_t cfg;

    crc32msb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // two-stage datapath: input register, fold logic, running CRC
    crc32msb_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .payload   (payload),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .crc_out   (crc_out)
    );

endmodule

/* hdl/crc32msb_checker.sv */
module crc32msb_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [crc32msb_pkg::DATA_W-1:0]   crc_out,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [crc32msb_pkg::ADDR_W-1:0]   paddr,
    input logic [crc32msb_pkg::DATA_W-1:0]   pwdata,
    input logic [crc32msb_pkg::DATA_W-1:0]   prdata,
    input logic                              pready
);

    logic       in_acc, out_acc, wr_acc, wide_addr;
    logic [1:0] pend_reg, pend_next;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign wr_acc    = psel && penable && pwrite && pready;
    assign wide_addr = (paddr[3:2] == crc32msb_pkg::REG_POLY)
                    || (paddr[3:2] == crc32msb_pkg::REG_START);

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(crc_out))
        else $error("stalled result changed");

    // no result without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without pending item");

    // both stages full and output blocked: input must be stalled
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 && out_stall |-> in_stall)
        else $error("item taken while pipeline full");

    // full-width register reads back what was just written
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        wr_acc && wide_addr ##1 psel && !pwrite && paddr == $past(paddr)
        |-> prdata == $past(pwdata))
        else $error("register readback mismatch");

endmodule

bind crc32_msb_first_configurable_top crc32msb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .crc_out   (crc_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);
